FILE: hw/rtl/slic_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list intersection package
// Sizes, command codes, and the control and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package slic_pkg;

  localparam int MAX_LISTS  = 8;
  localparam int LIST_DEPTH = 1024;

  localparam int SEL_W  = $clog2(MAX_LISTS);
  localparam int PTR_W  = $clog2(LIST_DEPTH);
  localparam int LEN_W  = PTR_W + 1;
  localparam int CNT_W  = $clog2(MAX_LISTS + 1);
  localparam int ADDR_W = SEL_W + PTR_W;
  localparam int ID_W   = 31;
  localparam int DOC_W  = 32;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 4;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  localparam logic signed [DOC_W-1:0] DOC_NONE      = '1;
  localparam logic signed [DOC_W-1:0] DOC_EXHAUSTED = {1'b0, {(DOC_W-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_NEXT    = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    TGT_VALUE,
    TGT_NONE,
    TGT_GOT,
    TGT_DOC
  } tgt_t;

  typedef enum logic [1:0] {
    LSEL_LEAD,
    LSEL_SECOND,
    LSEL_ITER
  } lsel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_NEXT_BEGIN,
    ST_ADV_RD,
    ST_ADV_CMP,
    ST_DISPATCH,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SECOND,
    PH_CATCH,
    PH_OTHER
  } phase_t;

  typedef struct packed {
    logic  append;
    logic  clear;
    logic  next_bump;
    logic  adv_begin;
    tgt_t  tgt;
    lsel_t lsel;
    logic  adv_read;
    logic  adv_step;
    logic  got_exh;
    logic  got_mem;
    logic  doc_load;
    logic  second_load;
    logic  iter_init;
    logic  iter_inc;
    logic  common_load;
    logic  out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic p_lt_len;
    logic mem_lt_target;
    logic moved;
    logic got_ne_doc;
    logic second_ne_got;
    logic got_gt_doc;
    logic iter_lt_n;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/sorted_list_intersection_core.sv
// ----------------------------------------------------------------------------
// Sorted list intersection core
// Leapfrog intersection over up to eight ascending id lists.
//
//   Channel  Direction  Contents (lowest bit first)
//   s_*      in         tdata: command[1:0], list_index[4:2], value[35:5]
//   m_*      out        tdata: doc_id[31:0], list_full[32]
//   cfg_*    in         lists_in_use[3:0]
//
// Append and clear pass through the start and done states before the result
// is registered. A query scans the lists through the single read port of the
// id store, with a read and a compare state for every store entry scanned.
// Reset clears lengths, cursors, started flags, the common id (to -1) and
// sets lists_in_use to 2; the id store itself is not cleared.
// One transaction is in flight; a new one is taken once the result
// register is free or being emptied.
// ----------------------------------------------------------------------------
module sorted_list_intersection_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // command[1:0], list_index[4:2], value[35:5], zero pad
  input  logic [slic_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // doc_id[31:0], list_full[32], zero pad
  output logic [slic_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         cfg_wr_en,
  input  logic [slic_pkg::CFG_W-1:0]   cfg_wr_data
);
  import slic_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;
  logic  accept;

  assign s_tready = in_ready;
  assign accept   = s_tvalid && in_ready;

  slic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .accept   (accept),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  slic_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_accept   (accept),
    .in_data     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

endmodule

FILE: hw/rtl/slic_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list intersection controller
// Sequences append and clear, and the list advances and leapfrog rounds of one query.
// ----------------------------------------------------------------------------
module slic_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  slic_pkg::stat_t stat,
  input  logic           accept,
  output slic_pkg::ctrl_t ctrl,
  output logic           in_ready
);
  import slic_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_LEAD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    ctrl       = '0;
    ctrl.tgt   = TGT_GOT;
    ctrl.lsel  = LSEL_LEAD;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = stat.out_free;
        // The datapath latches the item at the same edge.
        if (accept) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        unique case (stat.cmd)
          CMD_APPEND: begin
            ctrl.append = 1'b1;
            state_next  = ST_DONE;
          end
          CMD_CLEAR: begin
            ctrl.clear = 1'b1;
            state_next = ST_DONE;
          end
          CMD_NEXT: begin
            ctrl.next_bump = 1'b1;
            state_next     = ST_NEXT_BEGIN;
          end
          CMD_ADVANCE: begin
            ctrl.adv_begin = 1'b1;
            ctrl.tgt       = TGT_VALUE;
            ctrl.lsel      = LSEL_LEAD;
            phase_next     = PH_LEAD;
            state_next     = ST_ADV_RD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_NEXT_BEGIN: begin
        // After the step, reading the lead is an advance that never moves.
        ctrl.adv_begin = 1'b1;
        ctrl.tgt       = TGT_NONE;
        ctrl.lsel      = LSEL_LEAD;
        phase_next     = PH_LEAD;
        state_next     = ST_ADV_RD;
      end
      ST_ADV_RD: begin
        if (stat.p_lt_len) begin
          ctrl.adv_read = 1'b1;
          state_next    = ST_ADV_CMP;
        end else begin
          ctrl.got_exh = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_ADV_CMP: begin
        if (stat.mem_lt_target) begin
          ctrl.adv_step = 1'b1;
          state_next    = ST_ADV_RD;
        end else begin
          ctrl.got_mem = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (phase)
          PH_LEAD: begin
            ctrl.doc_load  = 1'b1;
            ctrl.adv_begin = 1'b1;
            ctrl.tgt       = TGT_GOT;
            ctrl.lsel      = LSEL_SECOND;
            phase_next     = PH_SECOND;
            state_next     = ST_ADV_RD;
          end
          PH_SECOND: begin
            ctrl.second_load = 1'b1;
            if (stat.got_ne_doc) begin
              ctrl.adv_begin = 1'b1;
              ctrl.tgt       = TGT_GOT;
              ctrl.lsel      = LSEL_LEAD;
              phase_next     = PH_CATCH;
              state_next     = ST_ADV_RD;
            end else begin
              ctrl.iter_init = 1'b1;
              state_next     = ST_ITER;
            end
          end
          PH_CATCH: begin
            ctrl.doc_load = 1'b1;
            if (stat.second_ne_got) begin
              ctrl.adv_begin = 1'b1;
              ctrl.tgt       = TGT_GOT;
              ctrl.lsel      = LSEL_SECOND;
              phase_next     = PH_SECOND;
              state_next     = ST_ADV_RD;
            end else begin
              ctrl.iter_init = 1'b1;
              state_next     = ST_ITER;
            end
          end
          PH_OTHER: begin
            // Only a list that was behind the candidate and overshot it
            // sends the lead forward again.
            if (stat.moved && stat.got_gt_doc) begin
              ctrl.adv_begin = 1'b1;
              ctrl.tgt       = TGT_GOT;
              ctrl.lsel      = LSEL_LEAD;
              phase_next     = PH_LEAD;
              state_next     = ST_ADV_RD;
            end else begin
              ctrl.iter_inc = 1'b1;
              state_next    = ST_ITER;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ITER: begin
        if (stat.iter_lt_n) begin
          ctrl.adv_begin = 1'b1;
          ctrl.tgt       = TGT_DOC;
          ctrl.lsel      = LSEL_ITER;
          phase_next     = PH_OTHER;
          state_next     = ST_ADV_RD;
        end else begin
          ctrl.common_load = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_DONE: begin
        ctrl.out_load = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_START)
    else $error("accepted transaction did not start the controller");

endmodule

FILE: hw/rtl/slic_datapath.sv
// ----------------------------------------------------------------------------
// Sorted list intersection datapath
// Id store, per-list length, cursor and started state, the advance scan
// registers and the result register.
// ----------------------------------------------------------------------------
module slic_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  slic_pkg::ctrl_t              ctrl,
  output slic_pkg::stat_t              stat,
  input  logic                         in_accept,
  input  logic [slic_pkg::IN_W-1:0]    in_data,
  input  logic                         cfg_wr_en,
  input  logic [slic_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slic_pkg::OUT_W-1:0]   out_data
);
  import slic_pkg::*;

  logic [ID_W-1:0] mem [MAX_LISTS*LIST_DEPTH];

  logic [LEN_W-1:0] length [MAX_LISTS];
  logic [LEN_W-1:0] cursor [MAX_LISTS];
  logic [MAX_LISTS-1:0] started;

  cmd_t                    cmd;
  logic [IDX_W-1:0]        idx;
  logic [ID_W-1:0]         value;
  logic [CFG_W-1:0]        lists_in_use;
  logic [SEL_W-1:0]        adv_sel;
  logic [LEN_W-1:0]        p;
  logic signed [DOC_W-1:0] target;
  logic                    moved;
  logic [ID_W-1:0]         rdata;
  logic signed [DOC_W-1:0] got;
  logic signed [DOC_W-1:0] doc;
  logic signed [DOC_W-1:0] second;
  logic signed [DOC_W-1:0] common;
  logic [CNT_W-1:0]        iter;
  logic                    full;
  logic signed [DOC_W-1:0] out_doc;
  logic                    out_full;

  logic [SEL_W-1:0]        sel;
  logic [LEN_W-1:0]        p_start;
  logic signed [DOC_W-1:0] tgt_mux;
  logic [CNT_W-1:0]        n_eff;
  logic                    idx_ok;
  logic                    has_room;

  always_comb begin
    unique case (ctrl.lsel)
      LSEL_LEAD:   sel = '0;
      LSEL_SECOND: sel = SEL_W'(1);
      LSEL_ITER:   sel = iter[SEL_W-1:0];
      default:     sel = '0;
    endcase
    unique case (ctrl.tgt)
      TGT_VALUE: tgt_mux = {1'b0, value};
      TGT_NONE:  tgt_mux = DOC_NONE;
      TGT_GOT:   tgt_mux = got;
      TGT_DOC:   tgt_mux = doc;
      default:   tgt_mux = got;
    endcase
    p_start = started[sel] ? cursor[sel] : '0;
    if (lists_in_use < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if ({{(32-CFG_W){1'b0}}, lists_in_use} > MAX_LISTS) begin
      n_eff = CNT_W'(MAX_LISTS);
    end else begin
      n_eff = CNT_W'(lists_in_use);
    end
    idx_ok   = {{(32-IDX_W){1'b0}}, idx} < MAX_LISTS;
    has_room = {{(32-LEN_W){1'b0}}, length[idx[SEL_W-1:0]]} < LIST_DEPTH;
  end

  always_comb begin
    stat.cmd           = cmd;
    stat.p_lt_len      = p < length[adv_sel];
    stat.mem_lt_target = $signed({1'b0, rdata}) < target;
    stat.moved         = moved;
    stat.got_ne_doc    = got != doc;
    stat.second_ne_got = second != got;
    stat.got_gt_doc    = got > doc;
    stat.iter_lt_n     = iter < n_eff;
    stat.out_free      = !out_valid || out_ready;
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.append && idx_ok && has_room) begin
      mem[{idx[SEL_W-1:0], length[idx[SEL_W-1:0]][PTR_W-1:0]}] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_read) begin
      rdata <= mem[{adv_sel, p[PTR_W-1:0]}];
    end
  end

  // Per-list control state.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        length[i] <= '0;
        cursor[i] <= '0;
      end
      started <= '0;
    end else begin
      if (ctrl.append && idx_ok && has_room) begin
        length[idx[SEL_W-1:0]] <= length[idx[SEL_W-1:0]] + LEN_W'(1);
      end
      if (ctrl.next_bump) begin
        if (!started[0]) begin
          started[0] <= 1'b1;
          cursor[0]  <= '0;
        end else if (cursor[0] < length[0]) begin
          cursor[0] <= cursor[0] + LEN_W'(1);
        end
      end
      if (ctrl.adv_begin) begin
        started[sel] <= 1'b1;
        cursor[sel]  <= p_start;
      end
      if (ctrl.adv_step) begin
        cursor[adv_sel] <= p + LEN_W'(1);
      end
    end
  end

  // Scan and leapfrog registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd   <= cmd_t'(in_data[1:0]);
      idx   <= in_data[4:2];
      value <= in_data[35:5];
    end
    if (ctrl.adv_begin) begin
      adv_sel <= sel;
      p       <= p_start;
      target  <= tgt_mux;
      moved   <= !started[sel];
    end
    if (ctrl.adv_step) begin
      p     <= p + LEN_W'(1);
      moved <= 1'b1;
    end
    if (ctrl.got_exh) begin
      got <= DOC_EXHAUSTED;
    end else if (ctrl.got_mem) begin
      got <= {1'b0, rdata};
    end
    if (ctrl.doc_load) begin
      doc <= got;
    end
    if (ctrl.second_load) begin
      second <= got;
    end
    if (ctrl.iter_init) begin
      iter <= CNT_W'(2);
    end else if (ctrl.iter_inc) begin
      iter <= iter + CNT_W'(1);
    end
    if (in_accept) begin
      full <= 1'b0;
    end else if (ctrl.append && idx_ok && !has_room) begin
      full <= 1'b1;
    end
    if (ctrl.out_load) begin
      out_doc  <= common;
      out_full <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lists_in_use <= CFG_W'(2);
      common       <= DOC_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lists_in_use <= cfg_wr_data;
      end
      if (ctrl.clear) begin
        common <= DOC_NONE;
      end else if (ctrl.common_load) begin
        common <= doc;
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {{(OUT_W-DOC_W-1){1'b0}}, out_full, out_doc};

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor[0] <= length[0])
    else $error("cursor ran past the list length");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    ctrl.adv_read |-> p < length[adv_sel])
    else $error("store read beyond the end of a list");

  a_clear_resets_common: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> common == DOC_NONE)
    else $error("clear did not reset the common id");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
